### hw/rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants of the round-robin slice scheduler: table
// geometry, action and result codes, and the interface of the shared adder.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned TIME_W      = 24;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned ACT_W       = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [DATA_W-1:0] QUANTUM_RST = DATA_W'(4);

  // input actions
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STEP  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SLICE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ALLDONE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOADED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REJECT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEARED = 3'd5;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;
    logic              carry;  // carry out on add, borrow on subtract
  } alu_rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] arrival;
    logic [DATA_W-1:0] burst;
    logic [DATA_W-1:0] remaining;
  } entry_t;

endpackage

### hw/rtl/round_robin_slice_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler
// Round-robin job scheduler with a programmable time quantum.
// ----------------------------------------------------------------------------
// Actions arrive one at a time on the input channel and each valid action
// yields exactly one result transfer (an unknown action yields none). Clear
// and load go from idle straight to the hand-over, as does a step once every
// loaded job has completed. Otherwise a step examines the job table one entry
// at a time (read, check) through the single read port of the table RAM,
// starting at the stored scan position and wrapping once to entry 0 when the
// pass already ran a job; it then runs a slice (length, time, remaining work,
// hand-over), with turnaround and waiting before the hand-over when the job
// completes, or an idle tick (tick, hand-over) when no entry is eligible. The
// walk over the table and the one shared 24-bit adder set a step's length.
// The input is ready only while the sequencer is idle; a finished result
// sits in an output register, so the next action may be accepted before it
// is taken. The quantum register is written at any configuration transfer;
// a quantum of zero acts as one. Time saturates at its maximum.
module round_robin_slice_scheduler (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rrs_pkg::ACT_W-1:0]    action_i,
  input  logic [rrs_pkg::DATA_W-1:0]   job_id_i,
  input  logic [rrs_pkg::DATA_W-1:0]   arrival_time_i,
  input  logic [rrs_pkg::DATA_W-1:0]   burst_time_i,

  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rrs_pkg::KIND_W-1:0]   kind_o,
  output logic [rrs_pkg::DATA_W-1:0]   run_id_o,
  output logic [rrs_pkg::DATA_W-1:0]   slice_length_o,
  output logic [rrs_pkg::TIME_W-1:0]   end_time_o,
  output logic                         finished_o,
  output logic [rrs_pkg::TIME_W-1:0]   turnaround_o,
  output logic [rrs_pkg::TIME_W-1:0]   waiting_o,

  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rrs_pkg::DATA_W-1:0]   cfg_quantum_i
);
  import rrs_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;  // wait for an action
  localparam logic [3:0] S_RD   = 4'd1;  // table read in flight
  localparam logic [3:0] S_CHK  = 4'd2;  // test entry for eligibility
  localparam logic [3:0] S_LEN  = 4'd3;  // slice = min(remaining, quantum)
  localparam logic [3:0] S_ADD  = 4'd4;  // advance time by the slice
  localparam logic [3:0] S_REM  = 4'd5;  // write back remaining work
  localparam logic [3:0] S_TA   = 4'd6;  // turnaround
  localparam logic [3:0] S_WT   = 4'd7;  // waiting
  localparam logic [3:0] S_TICK = 4'd8;  // idle tick
  localparam logic [3:0] S_DONE = 4'd9;  // hand result to output register

  logic [3:0]        state_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  completed_q;
  logic [TIME_W-1:0] time_q;
  logic [IDX_W-1:0]  scan_q;
  logic              ran_q;
  logic [DATA_W-1:0] quantum_q;

  // per-step working registers
  logic [IDX_W-1:0]  ptr_q;
  logic              wrap_q;
  entry_t            ent_q;
  logic [DATA_W-1:0] len_q;
  logic [TIME_W-1:0] ta_q;
  logic [TIME_W-1:0] wt_q;
  logic [KIND_W-1:0] res_kind_q;
  logic              res_fin_q;

  // output register
  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [DATA_W-1:0] run_id_q;
  logic [DATA_W-1:0] slice_q;
  logic [TIME_W-1:0] end_time_q;
  logic              finished_q;
  logic [TIME_W-1:0] turnaround_q;
  logic [TIME_W-1:0] waiting_q;

  logic              in_xfer;
  logic              load_ok;
  logic [DATA_W-1:0] q_eff;
  logic [CNT_W-1:0]  ptr_inc;
  logic              last_entry;
  logic [TIME_W-1:0] sat_sum;

  entry_t            rd_entry;
  entry_t            wr_entry;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i & in_ready_o;

  assign load_ok = in_xfer && (action_i == ACT_LOAD) && (burst_time_i != '0)
                   && (count_q < CNT_W'(MAX_ENTRIES));

  assign q_eff      = (quantum_q == '0) ? DATA_W'(1) : quantum_q;
  assign ptr_inc    = CNT_W'(ptr_q) + CNT_W'(1);
  assign last_entry = (ptr_inc >= count_q);
  assign sat_sum    = alu_rsp.carry ? TIME_MAX : alu_rsp.res;

  // Table: loads append at the fill count, slices write back remaining work.
  always_comb begin
    if (state_q == S_REM) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q;
      wr_entry  = ent_q;
      wr_entry.remaining = alu_rsp.res[DATA_W-1:0];
    end else begin
      ram_we    = load_ok;
      ram_waddr = count_q[IDX_W-1:0];
      wr_entry  = '{id: job_id_i, arrival: arrival_time_i,
                    burst: burst_time_i, remaining: burst_time_i};
    end
  end

  rrs_ram #(
    .Width ($bits(entry_t)),
    .Depth (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .raddr_i (ptr_q),
    .rdata_o (rd_entry)
  );

  // Operand selection for the shared adder, one operation per state.
  always_comb begin
    alu_req = '{op: ALU_SUB, a: '0, b: '0};
    case (state_q)
      S_CHK: begin
        alu_req = '{op: ALU_SUB, a: time_q, b: TIME_W'(rd_entry.arrival)};
      end
      S_LEN: begin
        alu_req = '{op: ALU_SUB, a: TIME_W'(ent_q.remaining), b: TIME_W'(q_eff)};
      end
      S_ADD: begin
        alu_req = '{op: ALU_ADD, a: time_q, b: TIME_W'(len_q)};
      end
      S_TICK: begin
        alu_req = '{op: ALU_ADD, a: time_q, b: TIME_W'(1)};
      end
      S_REM: begin
        alu_req = '{op: ALU_SUB, a: TIME_W'(ent_q.remaining), b: TIME_W'(len_q)};
      end
      S_TA: begin
        alu_req = '{op: ALU_SUB, a: time_q, b: TIME_W'(ent_q.arrival)};
      end
      S_WT: begin
        alu_req = '{op: ALU_SUB, a: ta_q, b: TIME_W'(ent_q.burst)};
      end
      default: begin
        alu_req = '{op: ALU_SUB, a: '0, b: '0};
      end
    endcase
  end

  rrs_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Control sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      completed_q <= '0;
      time_q      <= '0;
      scan_q      <= '0;
      ran_q       <= 1'b0;
      quantum_q   <= QUANTUM_RST;
      ptr_q       <= '0;
      wrap_q      <= 1'b0;
      ent_q       <= '0;
      len_q       <= '0;
      ta_q        <= '0;
      wt_q        <= '0;
      res_kind_q  <= KIND_SLICE;
      res_fin_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        quantum_q <= cfg_quantum_i;
      end
      // drop the held result once taken, unless a new one replaces it
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            res_fin_q <= 1'b0;
            case (action_i)
              ACT_CLEAR: begin
                count_q     <= '0;
                completed_q <= '0;
                time_q      <= '0;
                scan_q      <= '0;
                ran_q       <= 1'b0;
                res_kind_q  <= KIND_CLEARED;
                state_q     <= S_DONE;
              end
              ACT_LOAD: begin
                if (load_ok) begin
                  count_q    <= count_q + CNT_W'(1);
                  res_kind_q <= KIND_LOADED;
                end else begin
                  res_kind_q <= KIND_REJECT;
                end
                state_q <= S_DONE;
              end
              ACT_STEP: begin
                if (completed_q >= count_q) begin
                  res_kind_q <= KIND_ALLDONE;
                  state_q    <= S_DONE;
                end else begin
                  ptr_q   <= scan_q;
                  wrap_q  <= ran_q;
                  state_q <= S_RD;
                end
              end
              default: begin
                state_q <= S_IDLE;  // drop unknown action
              end
            endcase
          end
        end
        S_RD: begin
          state_q <= S_CHK;
        end
        S_CHK: begin
          // eligible: work left and arrival <= time (no borrow)
          if ((rd_entry.remaining != '0) && !alu_rsp.carry) begin
            ent_q   <= rd_entry;
            state_q <= S_LEN;
          end else if (last_entry) begin
            if (wrap_q) begin
              ptr_q   <= '0;
              wrap_q  <= 1'b0;
              state_q <= S_RD;
            end else begin
              state_q <= S_TICK;
            end
          end else begin
            ptr_q   <= ptr_inc[IDX_W-1:0];
            state_q <= S_RD;
          end
        end
        S_TICK: begin
          time_q     <= sat_sum;
          scan_q     <= '0;
          ran_q      <= 1'b0;
          res_kind_q <= KIND_IDLE;
          state_q    <= S_DONE;
        end
        S_LEN: begin
          len_q   <= alu_rsp.carry ? ent_q.remaining : q_eff;
          state_q <= S_ADD;
        end
        S_ADD: begin
          time_q  <= sat_sum;
          state_q <= S_REM;
        end
        S_REM: begin
          ent_q.remaining <= alu_rsp.res[DATA_W-1:0];
          res_kind_q      <= KIND_SLICE;
          if (last_entry) begin
            scan_q <= '0;
            ran_q  <= 1'b0;
          end else begin
            scan_q <= ptr_inc[IDX_W-1:0];
            ran_q  <= 1'b1;
          end
          if (alu_rsp.res[DATA_W-1:0] == '0) begin
            completed_q <= completed_q + CNT_W'(1);
            res_fin_q   <= 1'b1;
            state_q     <= S_TA;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_TA: begin
          ta_q    <= alu_rsp.res;
          state_q <= S_WT;
        end
        S_WT: begin
          // hold waiting at zero when turnaround is below the burst
          wt_q    <= alu_rsp.carry ? '0 : alu_rsp.res;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload: load when the sequencer hands over, zero unused fields.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
      kind_q       <= res_kind_q;
      run_id_q     <= (res_kind_q == KIND_SLICE) ? ent_q.id : '0;
      slice_q      <= (res_kind_q == KIND_SLICE) ? len_q : '0;
      end_time_q   <= (res_kind_q inside {KIND_SLICE, KIND_IDLE, KIND_ALLDONE})
                      ? time_q : '0;
      finished_q   <= res_fin_q;
      turnaround_q <= res_fin_q ? ta_q : '0;
      waiting_q    <= res_fin_q ? wt_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign run_id_o       = run_id_q;
  assign slice_length_o = slice_q;
  assign end_time_o     = end_time_q;
  assign finished_o     = finished_q;
  assign turnaround_o   = turnaround_q;
  assign waiting_o      = waiting_q;

`ifndef NO_ASSERTIONS
  a_completed_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    completed_q <= count_q)
    else $error("completed jobs exceed loaded jobs");

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_q == '0) || (CNT_W'(scan_q) < count_q))
    else $error("scan position beyond table fill");

  a_ran_implies_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ran_q |-> (scan_q != '0))
    else $error("pass marked as running at scan position zero");

  a_slice_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEN) |-> (ent_q.remaining != '0))
    else $error("slice started on a job without remaining work");

  a_slice_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |-> ((len_q != '0) && (len_q <= ent_q.remaining)))
    else $error("slice length out of range");
`endif

endmodule

### hw/rtl/rrs_ram.sv
// ----------------------------------------------------------------------------
// rrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/rrs_alu.sv
// ----------------------------------------------------------------------------
// rrs_alu
// Shared 24-bit adder/subtractor used for every time and length operation.
// ----------------------------------------------------------------------------
module rrs_alu (
  input  rrs_pkg::alu_req_t req_i,
  output rrs_pkg::alu_rsp_t rsp_o
);
  import rrs_pkg::*;

  logic [TIME_W:0] sum;

  always_comb begin
    if (req_i.op == ALU_ADD) begin
      sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end else begin
      sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end
    rsp_o.res   = sum[TIME_W-1:0];
    rsp_o.carry = sum[TIME_W];
  end

endmodule
